### rtl/core/trophic_level_set_walk_unit_macros.svh
// assertion macros for the trophic level walk
`ifndef TROPHIC_LEVEL_SET_WALK_UNIT_MACROS_SVH
`define TROPHIC_LEVEL_SET_WALK_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define TLSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlsw assertion failed");

// next-cycle implication, off during reset
`define TLSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlsw assertion failed");

`endif

### rtl/core/tlsw_pkg.sv
package tlsw_pkg;

  localparam int SPECIES_W = 4;
  localparam int LINK_W    = 16;
  localparam int LEVEL_W   = 33;
  localparam int CNT_W     = 5;
  localparam int RND_W     = 6;
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 5'd2;

  typedef struct packed {
    logic [SPECIES_W-1:0] row_index;
    logic [LINK_W-1:0]    predator_links;
    logic                 last_row;
  } row_item_t;

  typedef struct packed {
    logic [SPECIES_W-1:0] species_index;
    logic [LEVEL_W-1:0]   level_set;
    logic                 no_chain;
    logic                 last_species;
  } level_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 load_row;
    logic                 init;
    logic                 step;
    logic                 round_end;
    logic                 emit;
    logic [SPECIES_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic last_idx;
    logic more_rounds;
    logic out_free;
  } status_t;

endpackage

### rtl/core/tlsw_ctrl.sv
module tlsw_ctrl
  import tlsw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    row_valid,
  input  logic    last_row,
  input  status_t status,
  output logic    row_stall,
  output cmd_t    cmd
);

  state_t               state;
  state_t               state_next;
  logic [SPECIES_W-1:0] idx;
  logic [SPECIES_W-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (row_valid && last_row) state_next = ST_INIT;
      end
      ST_INIT: state_next = ST_WALK;
      ST_WALK: begin
        if (status.last_idx && !status.more_rounds) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.last_idx) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // species counter
  always_comb begin
    idx_next = idx;
    unique case (state)
      ST_INIT: idx_next = '0;
      ST_WALK: idx_next = status.last_idx ? '0 : idx + SPECIES_W'(1);
      ST_EMIT: begin
        if (status.out_free) idx_next = status.last_idx ? '0 : idx + SPECIES_W'(1);
      end
      default: idx_next = idx;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.idx   = idx;
    row_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        row_stall    = 1'b0;
        cmd.load_row = row_valid;
      end
      ST_INIT: cmd.init = 1'b1;
      ST_WALK: begin
        cmd.step      = 1'b1;
        cmd.round_end = status.last_idx;
      end
      ST_EMIT: cmd.emit = status.out_free;
      default: row_stall = 1'b1;
    endcase
  end

endmodule

### rtl/core/tlsw_datapath.sv
module tlsw_datapath
  import tlsw_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  row_item_t         row_item,
  input  cmd_t              cmd,
  input  logic              level_stall,
  output logic              level_valid,
  output level_item_t       level_item,
  output status_t           status
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [CNT_W-1:0]   species_count;
  logic [SLOTS-1:0]   rows [SLOTS];
  logic [LEVEL_W-1:0] masks [SLOTS];
  logic [RND_W-1:0]   round;
  logic               fired;

  logic [CNT_W-1:0]   n_use;
  logic [SLOTS-1:0]   use_mask;
  logic [SLOTS-1:0]   eaten;
  logic [IW-1:0]      cur_idx;
  logic [SLOTS-1:0]   preds;
  logic [LEVEL_W-1:0] cur_mask;
  logic [LEVEL_W-1:0] round_bit;
  logic [LEVEL_W-1:0] below;
  logic [LEVEL_W-1:0] next_bit;
  logic               active;
  logic               fire_this;
  logic               fire_any;
  logic [RND_W-1:0]   round_plus;
  logic [RND_W-1:0]   two_n;
  logic               row_in_range;

  // species in use, saturated to 2..SLOTS
  always_comb begin
    if (species_count < COUNT_MIN) n_use = COUNT_MIN;
    else if (species_count > CNT_W'(SLOTS)) n_use = CNT_W'(SLOTS);
    else n_use = species_count;
  end

  always_comb begin
    for (int j = 0; j < SLOTS; j++) use_mask[j] = (CNT_W'(j) < n_use);
  end

  // a species is eaten when another species in use has it as predator
  always_comb begin
    eaten = '0;
    for (int i = 0; i < SLOTS; i++) begin
      for (int r = 0; r < SLOTS; r++) begin
        if (r != i && use_mask[r] && rows[r][i]) eaten[i] = 1'b1;
      end
    end
  end

  assign cur_idx   = cmd.idx[IW-1:0];
  assign preds     = rows[cur_idx] & use_mask;
  assign cur_mask  = masks[cur_idx];
  assign round_bit = LEVEL_W'(1) << round;
  assign below     = round_bit - LEVEL_W'(1);
  assign next_bit  = round_bit << 1;
  assign active    = ((cur_mask & round_bit) != '0) && ((cur_mask & below) == '0);
  assign fire_this = active && (preds != '0);
  assign fire_any  = fired || fire_this;
  assign round_plus = round + RND_W'(1);
  assign two_n      = {n_use, 1'b0};
  assign row_in_range = CNT_W'(row_item.row_index) < CNT_W'(SLOTS);

  assign status.last_idx    = CNT_W'(cmd.idx) == (n_use - CNT_W'(1));
  assign status.more_rounds = fire_any && (round_plus < two_n);
  assign status.out_free    = !level_valid || !level_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      species_count <= COUNT_RESET;
    end else if (cfg_we) begin
      species_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && row_in_range) begin
      rows[row_item.row_index[IW-1:0]] <= row_item.predator_links[SLOTS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < SLOTS; i++) masks[i] <= eaten[i] ? '0 : LEVEL_W'(1);
    end else if (cmd.step && active) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (preds[j]) masks[j] <= masks[j] | next_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
      fired <= 1'b0;
    end else if (cmd.init) begin
      round <= '0;
      fired <= 1'b0;
    end else if (cmd.step) begin
      if (cmd.round_end) begin
        round <= round_plus;
        fired <= 1'b0;
      end else begin
        fired <= fire_any;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (cmd.emit) begin
      level_valid <= 1'b1;
    end else if (!level_stall) begin
      level_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      level_item.species_index <= cmd.idx;
      level_item.level_set     <= cur_mask;
      level_item.no_chain      <= (cur_mask == '0);
      level_item.last_species  <= status.last_idx;
    end
  end

endmodule

### rtl/core/trophic_level_set_walk_unit.sv
// rows load at one per cycle while the controller is idle; a non-final row causes no result
// after the final row: a setup state, then R walk rounds (R in 1..2n), one species a cycle
// then n results, one per cycle while level_stall stays low; rows are held off until then
// the walk loop over species in the shared datapath sets the burst length
// rst (sync, high): controller idle, species_count 16, no result pending; link rows undefined
`include "trophic_level_set_walk_unit_macros.svh"

module trophic_level_set_walk_unit
  import tlsw_pkg::*;
#(
  parameter int MAX_SPECIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  // species_count register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  // link row requests
  input  logic              row_valid,
  output logic              row_stall,
  input  row_item_t         row_item,
  // per-species level results
  output logic              level_valid,
  input  logic              level_stall,
  output level_item_t       level_item
);

  // row storage never exceeds the row width
  localparam int SLOTS = (MAX_SPECIES < LINK_W) ? MAX_SPECIES : LINK_W;

  cmd_t    cmd;
  status_t status;

  // the register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: idle, setup, walk rounds, emit
  tlsw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .last_row  (row_item.last_row),
    .status    (status),
    .row_stall (row_stall),
    .cmd       (cmd)
  );

  // link rows, level masks, round state and result register
  tlsw_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .row_item    (row_item),
    .cmd         (cmd),
    .level_stall (level_stall),
    .level_valid (level_valid),
    .level_item  (level_item),
    .status      (status)
  );

  // a final row always starts a walk, so rows are held off right after it
  `TLSW_ASSERT_NEXT(a_walk_after_last_row, row_valid && !row_stall && row_item.last_row, row_stall)
  // a stalled result stays valid and unchanged until taken
  `TLSW_ASSERT_NEXT(a_result_held, level_valid && level_stall, $stable({level_valid, level_item}))
  // results are only loaded while emitting, never while taking rows
  `TLSW_ASSERT_NEXT(a_no_result_when_idle, !row_stall && level_valid && !level_stall, !level_valid)

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsw_pkg::*;

  // longest stretch without any handshake before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 4000;
  // receiver hold-off during the back-pressure phase
  localparam int unsigned HOLD_CYCLES  = 400;
  // settle time before a count write, covers rows still loading
  localparam int unsigned SETTLE       = 8;
  // drain time at the end, long enough for a full walk of 16 species
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned PLAN_ROWS    = 24;
  localparam int unsigned ROWS         = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic        row_valid = 1'b0;
  logic        row_stall;
  row_item_t   row_item = '0;
  logic        level_valid;
  logic        level_stall = 1'b0;
  level_item_t level_item;

  trophic_level_set_walk_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .row_valid   (row_valid),
    .row_stall   (row_stall),
    .row_item    (row_item),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .level_item  (level_item)
  );

  // directed requests; a set count entry writes the register before its row
  typedef struct packed {
    logic               set_count;
    logic [CNT_W-1:0]   count;
    logic [SPECIES_W-1:0] row;
    logic [LINK_W-1:0]  links;
    logic               last;
    logic               typed;
    logic [LEVEL_W-1:0] level;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    // fill every link row once so no walk ever reads an unwritten row
    '{1'b0, 5'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd1,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd2,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd3,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd4,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd5,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd6,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd7,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd8,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd9,  16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd10, 16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd11, 16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd12, 16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd13, 16'h0000, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd14, 16'h0000, 1'b0, 1'b0, 33'd0},
    // empty web at reset count: every species a producer at level 0
    '{1'b0, 5'd0,  4'd15, 16'h0000, 1'b1, 1'b1, 33'h1},
    // everyone eats species 0, self link included
    '{1'b0, 5'd0,  4'd0,  16'hffff, 1'b1, 1'b0, 33'd0},
    // count 0 saturates to 2; two species eating each other, no producer
    '{1'b1, 5'd0,  4'd0,  16'h0002, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd1,  16'h0001, 1'b1, 1'b1, 33'd0},
    // count 31 saturates to 16
    '{1'b1, 5'd31, 4'd3,  16'hffff, 1'b1, 1'b0, 33'd0},
    // count 1 saturates to 2; links to species out of use are ignored
    '{1'b1, 5'd1,  4'd1,  16'hfffc, 1'b1, 1'b0, 33'd0},
    // count 17 saturates to 16; self link only keeps a producer
    '{1'b1, 5'd17, 4'd15, 16'h8000, 1'b1, 1'b0, 33'd0},
    // smallest web, both species producers
    '{1'b1, 5'd2,  4'd2,  16'hffff, 1'b0, 1'b0, 33'd0},
    '{1'b0, 5'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 33'h1}
  };

  // predictor state: link rows as loaded, species in use, walk result
  logic [LINK_W-1:0]  link_shadow [ROWS];
  logic [LEVEL_W-1:0] walk_masks  [ROWS];
  int unsigned        species_n = 16;
  level_item_t        level_q [$];

  int unsigned error_count  = 0;
  int unsigned rows_sent    = 0;
  int unsigned send_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_count   = 0;
  int unsigned quiet_cycles = 0;
  logic        hold_req     = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // lowest level per species spreads one round at a time from the producers
  function automatic void run_level_walk(input int unsigned n);
    logic [LINK_W-1:0] in_use;
    logic [LINK_W-1:0] preds;
    bit                producer;
    bit                fired;
    int unsigned       t;
    int unsigned       low;
    in_use = (n >= LINK_W) ? '1 : LINK_W'((32'd1 << n) - 1);
    for (int i = 0; i < ROWS; i++) walk_masks[i] = '0;
    // producers: eaten-by links aside, nothing but themselves as prey
    for (int i = 0; i < n; i++) begin
      producer = 1'b1;
      for (int r = 0; r < n; r++) begin
        if (r != i && link_shadow[r][i]) producer = 1'b0;
      end
      if (producer) walk_masks[i] = LEVEL_W'(1);
    end
    t = 0;
    fired = 1'b1;
    while (fired && t < 2 * n) begin
      fired = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (walk_masks[i] == '0) continue;
        low = 0;
        while (!walk_masks[i][low]) low++;
        if (low != t) continue;
        preds = link_shadow[i] & in_use;
        for (int j = 0; j < n; j++) begin
          if (preds[j]) begin
            fired = 1'b1;
            walk_masks[j][t+1] = 1'b1;
          end
        end
      end
      t++;
    end
  endfunction

  // offer one request, wait for it to be taken, then update the predictor
  task automatic send_row(input row_item_t it, input bit typed = 1'b0,
                          input logic [LEVEL_W-1:0] typed_level = '0);
    level_item_t  e;
    logic [LEVEL_W-1:0] lvl;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      row_valid <= 1'b0;
      @(posedge clk);
    end
    row_valid <= 1'b1;
    row_item  <= it;
    do @(posedge clk); while (row_stall);
    rows_sent++;
    link_shadow[it.row_index] = it.predator_links;
    if (it.last_row) begin
      run_level_walk(species_n);
      for (int i = 0; i < species_n; i++) begin
        lvl = typed ? typed_level : walk_masks[i];
        e.species_index = SPECIES_W'(i);
        e.level_set     = lvl;
        e.no_chain      = (lvl == '0);
        e.last_species  = (i == species_n - 1);
        level_q = {level_q, e};
      end
    end
  endtask

  // register write only with the block idle and every result drained
  task automatic write_count(input logic [CNT_W-1:0] value);
    row_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // saturates to 2..16
    species_n = (value < COUNT_MIN) ? COUNT_MIN : (value > ROWS) ? ROWS : value;
  endtask

  // one full web: every row in use, rotated order, final row starts the walk
  task automatic send_web(input int unsigned n);
    row_item_t         it;
    logic [LINK_W-1:0] in_use;
    logic [LINK_W-1:0] links;
    int unsigned       style;
    int unsigned       off;
    int unsigned       r;
    in_use = (n >= LINK_W) ? '1 : LINK_W'((32'd1 << n) - 1);
    style  = $urandom_range(3);
    off    = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      r = (k + off) % n;
      case (style)
        0:       links = LINK_W'(1) << (r + 1);                  // food chain, deep levels
        1:       links = LINK_W'($urandom & $urandom & $urandom); // sparse random
        2:       links = LINK_W'($urandom);                      // dense random
        default: links = ($urandom_range(3) == 0) ? LINK_W'(1) << r : '0;
      endcase
      // junk links to species out of use
      if ($urandom_range(2) == 0) links |= LINK_W'($urandom) & ~in_use;
      it.row_index      = SPECIES_W'(r);
      it.predator_links = links;
      it.last_row       = (k == n - 1);
      send_row(it);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input int unsigned s_pct,
                           input int unsigned l_pct, input bit pressure,
                           input int unsigned quota);
    row_item_t   it;
    int unsigned stop_at;
    write_count(count);
    send_pct  = s_pct;
    stall_pct <= l_pct;
    if (pressure) hold_req <= 1'b1;
    stop_at = rows_sent + quota;
    while (rows_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        // stray request: any row, any links, sometimes a premature walk
        it.row_index      = SPECIES_W'($urandom);
        it.predator_links = LINK_W'($urandom);
        it.last_row       = ($urandom_range(2) == 0);
        send_row(it);
      end else begin
        send_web(species_n);
      end
    end
  endtask

  // receiver: one long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      level_stall <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      level_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    level_item_t want;
    if (!rst && level_valid && !level_stall) begin
      if (level_q.size() == 0) begin
        report_mismatch("result with nothing expected", level_item.species_index, '0);
      end else begin
        want = level_q.pop_front();
        if (level_item.species_index !== want.species_index)
          report_mismatch("species_index", level_item.species_index, want.species_index);
        if (level_item.level_set !== want.level_set)
          report_mismatch("level_set", level_item.level_set, want.level_set);
        if (level_item.no_chain !== want.no_chain)
          report_mismatch("no_chain", level_item.no_chain, want.no_chain);
        if (level_item.last_species !== want.last_species)
          report_mismatch("last_species", level_item.last_species, want.last_species);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((row_valid && !row_stall) || (level_valid && !level_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling
    for (int p = 0; p < PLAN_ROWS; p++) begin
      if (plan[p].set_count) write_count(plan[p].count);
      it.row_index      = plan[p].row;
      it.predator_links = plan[p].links;
      it.last_row       = plan[p].last;
      send_row(it, plan[p].typed, plan[p].level);
    end

    // random part: count, sender idle %, receiver stall %, hold-off, requests
    run_phase(5'd5, 0, 0, 1'b0, 68);
    run_phase(5'd16, 79, 0, 1'b0, 68);
    run_phase(5'd3, 0, 79, 1'b0, 68);
    run_phase(CNT_W'($urandom), 8, 8, 1'b0, 68);
    // back-pressure: receiver holds off while the sender keeps offering
    run_phase(5'd11, 0, 0, 1'b1, 68);
    run_phase(CNT_W'($urandom_range(2, 16)), 0, 0, 1'b0, 68);

    row_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (level_q.size() != 0)
      report_mismatch("results never arrived", level_q.size(), '0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### trophic_level_set_walk_unit.f
+incdir+rtl/core
rtl/core/tlsw_pkg.sv
rtl/core/tlsw_ctrl.sv
rtl/core/tlsw_datapath.sv
rtl/core/trophic_level_set_walk_unit.sv
test/testbench.sv
